// ===== hw/rtl/trp_pkg.sv =====
// Shared constants, opcodes and types for the turtle raster plotter.
package trp_pkg;

    // Grid geometry
    localparam int GRID_SIZE  = 64;
    localparam int POS_W      = 6;
    localparam int ROW_AW     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int ROW_BITS_W = 64;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(GRID_SIZE - 1);

    // Input item fields
    localparam int OPCODE_W  = 4;
    localparam int STEP_W    = 8;
    localparam int S_TDATA_W = 16;

    // Result item fields
    localparam int M_FIELDS_W = POS_W + ROW_BITS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PEN_UP     = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_PEN_DOWN   = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_TURN_RIGHT = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_TURN_LEFT  = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_MOVE       = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_PRINT      = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_END        = 4'd9;

    // Heading codes
    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    // Result of one step of the position unit
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             moved;
    } step_res_t;

endpackage

// ===== hw/rtl/turtle_raster_plotter.sv =====
// Top level of the turtle raster plotter: command sequencer, step unit and bitmap.
//
// Takes one turtle command per item on the slave stream and plots on a GRID_SIZE square
// one-bit bitmap that reads as cleared straight after reset (per-row valid bits, so there
// is no clearing pass). The block takes no new item while a command is in progress. Pen
// up, turns, end and undefined opcodes complete in the cycle that accepts them. Pen down
// reads the current row when accepted and writes it back in MV_MARK, a read-modify-write
// through the bitmap's single read port and single write port. A move runs the step unit
// in MV_STEP once per step, with a row update in MV_MARK after each step with the pen
// down, and it finishes as soon as the step count runs out or a step is blocked at the
// grid edge. A print streams GRID_SIZE rows on the master stream, one per cycle from the
// registered read port while m_tready is high; tlast marks the final row. After an end
// command items are still accepted but dropped until reset.
module turtle_raster_plotter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: opcode [3:0], step_count [11:4], zero [15:12]
    input  logic [trp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: row_number [5:0], row_bits [69:6], zero [71:70]
    output logic [trp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    typedef enum logic [1:0] {
        IDLE,
        MV_STEP,
        MV_MARK,
        PRINT
    } state_t;

    state_t                          state_reg;
    logic [trp_pkg::POS_W-1:0]       pos_row_reg;
    logic [trp_pkg::POS_W-1:0]       pos_col_reg;
    logic [1:0]                      heading_reg;
    logic                            pen_reg;
    logic                            halted_reg;
    logic [trp_pkg::STEP_W-1:0]      cnt_reg;
    logic [trp_pkg::POS_W-1:0]       prow_reg;
    logic                            out_valid_reg;
    logic [trp_pkg::POS_W-1:0]       out_row_reg;
    logic [trp_pkg::ROW_BITS_W-1:0]  out_bits_reg;
    logic                            out_last_reg;

    logic [trp_pkg::OPCODE_W-1:0]    in_opcode;
    logic [trp_pkg::STEP_W-1:0]      in_steps;
    logic                            accept;
    logic                            load_fire;
    logic                            prow_last;
    logic [trp_pkg::POS_W-1:0]       prow_inc;
    trp_pkg::step_res_t              step;
    logic [trp_pkg::ROW_AW-1:0]      rd_addr;
    logic [trp_pkg::ROW_BITS_W-1:0]  rd_data;
    logic                            wr_en;
    logic [trp_pkg::ROW_BITS_W-1:0]  wr_data;

    // input item fields
    assign in_opcode = s_tdata[3:0];
    assign in_steps  = s_tdata[11:4];
    assign s_tready  = (state_reg == IDLE);
    assign accept    = s_tvalid && s_tready;

    // print: next row goes out when the output register is free
    assign load_fire = (state_reg == PRINT) && (!out_valid_reg || m_tready);
    assign prow_last = (prow_reg == trp_pkg::MAX_POS);
    assign prow_inc  = prow_reg + 1'b1;

    trp_step_unit u_step (
        .heading (heading_reg),
        .pos_row (pos_row_reg),
        .pos_col (pos_col_reg),
        .res     (step)
    );

    // read address: row about to be marked or printed
    always_comb
    begin
        case (state_reg)
            IDLE:
            begin
                if (in_opcode == trp_pkg::OP_PEN_DOWN)
                begin
                    rd_addr = pos_row_reg[trp_pkg::ROW_AW-1:0];
                end
                else
                begin
                    rd_addr = '0;
                end
            end
            MV_STEP: rd_addr = step.row[trp_pkg::ROW_AW-1:0];
            PRINT:
            begin
                if (load_fire)
                begin
                    rd_addr = prow_inc[trp_pkg::ROW_AW-1:0];
                end
                else
                begin
                    rd_addr = prow_reg[trp_pkg::ROW_AW-1:0];
                end
            end
            default: rd_addr = pos_row_reg[trp_pkg::ROW_AW-1:0];
        endcase
    end

    // mark the current cell into the row just read
    assign wr_en   = (state_reg == MV_MARK);
    assign wr_data = rd_data | (trp_pkg::ROW_BITS_W'(1) << pos_col_reg);

    trp_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (pos_row_reg[trp_pkg::ROW_AW-1:0]),
        .wr_data (wr_data)
    );

    // sequencer, turtle state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            pos_row_reg   <= '0;
            pos_col_reg   <= '0;
            heading_reg   <= trp_pkg::HEAD_RIGHT;
            pen_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            cnt_reg       <= '0;
            prow_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_bits_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // output handshake
            if (load_fire)
            begin
                out_valid_reg <= 1'b1;
                out_row_reg   <= prow_reg;
                out_bits_reg  <= rd_data;
                out_last_reg  <= prow_last;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (accept && !halted_reg)
                    begin
                        case (in_opcode)
                            trp_pkg::OP_PEN_UP:
                            begin
                                pen_reg <= 1'b0;
                            end
                            trp_pkg::OP_PEN_DOWN:
                            begin
                                pen_reg   <= 1'b1;
                                cnt_reg   <= '0;
                                state_reg <= MV_MARK;
                            end
                            trp_pkg::OP_TURN_RIGHT:
                            begin
                                heading_reg <= heading_reg + 2'd1;
                            end
                            trp_pkg::OP_TURN_LEFT:
                            begin
                                heading_reg <= heading_reg + 2'd3;
                            end
                            trp_pkg::OP_MOVE:
                            begin
                                if (in_steps != '0)
                                begin
                                    cnt_reg   <= in_steps;
                                    state_reg <= MV_STEP;
                                end
                            end
                            trp_pkg::OP_PRINT:
                            begin
                                prow_reg  <= '0;
                                state_reg <= PRINT;
                            end
                            trp_pkg::OP_END:
                            begin
                                halted_reg <= 1'b1;
                            end
                            default:
                            begin
                                halted_reg <= halted_reg;
                            end
                        endcase
                    end
                end
                MV_STEP:
                begin
                    // blocked at the edge: the rest of the move changes nothing
                    if (!step.moved)
                    begin
                        state_reg <= IDLE;
                    end
                    else
                    begin
                        pos_row_reg <= step.row;
                        pos_col_reg <= step.col;
                        cnt_reg     <= cnt_reg - 1'b1;
                        if (pen_reg)
                        begin
                            state_reg <= MV_MARK;
                        end
                        else if (cnt_reg == trp_pkg::STEP_W'(1))
                        begin
                            state_reg <= IDLE;
                        end
                    end
                end
                MV_MARK:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= IDLE;
                    end
                    else
                    begin
                        state_reg <= MV_STEP;
                    end
                end
                PRINT:
                begin
                    if (load_fire)
                    begin
                        prow_reg <= prow_inc;
                        if (prow_last)
                        begin
                            state_reg <= IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{trp_pkg::M_PAD_W{1'b0}}, out_bits_reg, out_row_reg};

endmodule

// ===== hw/rtl/trp_step_unit.sv =====
// Position step unit: one cell forward along the heading, held at the grid edge.
module trp_step_unit (
    input  logic [1:0]              heading,
    input  logic [trp_pkg::POS_W-1:0] pos_row,
    input  logic [trp_pkg::POS_W-1:0] pos_col,
    output trp_pkg::step_res_t      res
);

    // one increment or decrement with its edge compare
    always_comb
    begin
        res.row   = pos_row;
        res.col   = pos_col;
        res.moved = 1'b0;
        case (heading)
            trp_pkg::HEAD_RIGHT:
            begin
                if (pos_col < trp_pkg::MAX_POS)
                begin
                    res.col   = pos_col + 1'b1;
                    res.moved = 1'b1;
                end
            end
            trp_pkg::HEAD_DOWN:
            begin
                if (pos_row < trp_pkg::MAX_POS)
                begin
                    res.row   = pos_row + 1'b1;
                    res.moved = 1'b1;
                end
            end
            trp_pkg::HEAD_LEFT:
            begin
                if (pos_col != '0)
                begin
                    res.col   = pos_col - 1'b1;
                    res.moved = 1'b1;
                end
            end
            trp_pkg::HEAD_UP:
            begin
                if (pos_row != '0)
                begin
                    res.row   = pos_row - 1'b1;
                    res.moved = 1'b1;
                end
            end
            default:
            begin
                res.moved = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/trp_bitmap.sv =====
// Bitmap store: one row per entry, registered read, row valid bits cleared by reset.
module trp_bitmap (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [trp_pkg::ROW_AW-1:0]     rd_addr,
    output logic [trp_pkg::ROW_BITS_W-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [trp_pkg::ROW_AW-1:0]     wr_addr,
    input  logic [trp_pkg::ROW_BITS_W-1:0] wr_data
);

    logic [trp_pkg::ROW_BITS_W-1:0] mem [trp_pkg::GRID_SIZE];
    logic [trp_pkg::ROW_BITS_W-1:0] rd_mem_reg;
    logic [trp_pkg::GRID_SIZE-1:0]  valid_reg;
    logic                           rd_valid_reg;

    // row storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    // a row never written reads as cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

// ===== hw/rtl/trp_checker.sv =====
// Port-level checks for the turtle raster plotter, bound to the top level.
module trp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [trp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result item changed while stalled");

    // tlast flags exactly the final grid row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == trp_pkg::MAX_POS)))
    else $error("tlast does not match the final row");

    // rows in flight before the last one keep the command port closed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
    else $error("command accepted in the middle of a print");

    // padding bits of a result item stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[trp_pkg::M_TDATA_W-1:trp_pkg::M_FIELDS_W] == '0))
    else $error("padding bits set in a result item");

endmodule

bind turtle_raster_plotter trp_checker u_trp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/tb_turtle_raster_plotter.sv =====
// Self-checking testbench for the turtle raster plotter: directed and random command streams.
`timescale 1ns / 1ps

module tb_turtle_raster_plotter;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 300;   // longer than the slowest command

    typedef struct packed {
        logic [trp_pkg::POS_W-1:0]      row_number;
        logic [trp_pkg::ROW_BITS_W-1:0] row_bits;
        logic                           last_row;
    } plot_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [trp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [trp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    // Predicted turtle state
    logic [trp_pkg::ROW_BITS_W-1:0] canvas [0:trp_pkg::GRID_SIZE-1];
    logic [trp_pkg::POS_W-1:0]      turtle_row;
    logic [trp_pkg::POS_W-1:0]      turtle_col;
    logic [1:0]                     turtle_heading;
    logic                           pen_is_down;
    logic                           plotter_halted;

    plot_row_t pending_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int commands_sent = 0;
    int prints_sent = 0;
    int rows_checked = 0;
    int cycle_count = 0;

    logic [trp_pkg::OPCODE_W-1:0] undefined_ops [9] = '{4'd0, 4'd7, 4'd8, 4'd10, 4'd11,
                                                         4'd12, 4'd13, 4'd14, 4'd15};

    turtle_raster_plotter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Clear the predicted canvas and turtle
    function automatic void reset_turtle();
        for (int r = 0; r < trp_pkg::GRID_SIZE; r++)
            canvas[r] = '0;
        turtle_row     = '0;
        turtle_col     = '0;
        turtle_heading = trp_pkg::HEAD_RIGHT;
        pen_is_down    = 1'b0;
        plotter_halted = 1'b0;
    endfunction

    // Apply one command to the predicted state, queue any rows it prints
    function automatic void plot_command(input logic [trp_pkg::OPCODE_W-1:0] op,
                                         input logic [trp_pkg::STEP_W-1:0] steps);
        logic [trp_pkg::ROW_BITS_W-1:0] col_mask;
        plot_row_t                      row_item;
        col_mask = (trp_pkg::GRID_SIZE >= 64) ? '1
                 : ((trp_pkg::ROW_BITS_W'(1) << trp_pkg::GRID_SIZE) - 1);
        if (plotter_halted)
            return;
        case (op)
            trp_pkg::OP_PEN_UP:
                pen_is_down = 1'b0;
            trp_pkg::OP_PEN_DOWN:
            begin
                pen_is_down = 1'b1;
                canvas[turtle_row][turtle_col] = 1'b1;
            end
            trp_pkg::OP_TURN_RIGHT:
                turtle_heading = turtle_heading + 2'd1;
            trp_pkg::OP_TURN_LEFT:
                turtle_heading = turtle_heading + 2'd3;
            trp_pkg::OP_MOVE:
                for (int s = 0; s < steps; s++)
                begin
                    case (turtle_heading)
                        trp_pkg::HEAD_RIGHT: if (turtle_col < trp_pkg::MAX_POS) turtle_col++;
                        trp_pkg::HEAD_DOWN:  if (turtle_row < trp_pkg::MAX_POS) turtle_row++;
                        trp_pkg::HEAD_LEFT:  if (turtle_col > 0) turtle_col--;
                        default:             if (turtle_row > 0) turtle_row--;
                    endcase
                    if (pen_is_down)
                        canvas[turtle_row][turtle_col] = 1'b1;
                end
            trp_pkg::OP_PRINT:
                for (int r = 0; r < trp_pkg::GRID_SIZE; r++)
                begin
                    row_item.row_number = trp_pkg::POS_W'(r);
                    row_item.row_bits   = canvas[r] & col_mask;
                    row_item.last_row   = (r == trp_pkg::GRID_SIZE - 1);
                    pending_rows.push_back(row_item);
                end
            trp_pkg::OP_END:
                plotter_halted = 1'b1;
            default:
                ;   // undefined opcode: no effect
        endcase
    endfunction

    // Prediction on accepted commands, comparison on accepted rows
    always @(posedge clk)
    begin : row_monitor
        plot_row_t got;
        plot_row_t want;
        if (rst_n && s_tvalid && s_tready === 1'b1)
            plot_command(s_tdata[trp_pkg::OPCODE_W-1:0],
                         s_tdata[trp_pkg::OPCODE_W +: trp_pkg::STEP_W]);
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got.row_number = m_tdata[trp_pkg::POS_W-1:0];
            got.row_bits   = m_tdata[trp_pkg::POS_W +: trp_pkg::ROW_BITS_W];
            got.last_row   = m_tlast;
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected row: row %0d bits %h last %b", $time,
                         got.row_number, got.row_bits, got.last_row);
                error_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (got.row_number !== want.row_number)
                begin
                    $display("%0t: row_number mismatch: expected %0d actual %0d", $time,
                             want.row_number, got.row_number);
                    error_count++;
                end
                if (got.row_bits !== want.row_bits)
                begin
                    $display("%0t: row_bits mismatch on row %0d: expected %h actual %h",
                             $time, want.row_number, want.row_bits, got.row_bits);
                    error_count++;
                end
                if (got.last_row !== want.last_row)
                begin
                    $display("%0t: last_row mismatch on row %0d: expected %b actual %b",
                             $time, want.row_number, want.last_row, got.last_row);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d rows outstanding", $time, pending_rows.size());
        $display("turtle_raster_plotter verification failed");
        $finish;
    end

    // Send one command item, with random sender gaps beforehand
    task automatic send_command(input logic [trp_pkg::OPCODE_W-1:0] op,
                                input logic [trp_pkg::STEP_W-1:0] steps);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= trp_pkg::S_TDATA_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, steps, op};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        commands_sent++;
        if (op == trp_pkg::OP_PRINT)
            prints_sent++;
    endtask

    // Drop valid, wait for all rows, then let the block settle
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Edges, saturated step counts and every drawing command
    task automatic test_directed_plot();
        send_command(trp_pkg::OP_PRINT, 8'd0);         // empty canvas after reset
        send_command(trp_pkg::OP_PEN_DOWN, 8'd0);      // marks the origin
        send_command(trp_pkg::OP_MOVE, 8'd255);        // runs into the right edge
        send_command(trp_pkg::OP_TURN_RIGHT, 8'd0);
        send_command(trp_pkg::OP_MOVE, 8'd0);          // zero steps
        send_command(trp_pkg::OP_MOVE, 8'd70);         // down to the bottom edge
        send_command(trp_pkg::OP_TURN_RIGHT, 8'd0);
        send_command(trp_pkg::OP_PEN_UP, 8'd0);
        send_command(trp_pkg::OP_MOVE, 8'd10);         // travel without marking
        send_command(trp_pkg::OP_PEN_DOWN, 8'd0);
        send_command(trp_pkg::OP_MOVE, 8'd255);        // left edge
        send_command(trp_pkg::OP_TURN_LEFT, 8'd0);     // facing down, at the bottom
        send_command(trp_pkg::OP_MOVE, 8'd5);          // pushes against the edge
        send_command(trp_pkg::OP_TURN_LEFT, 8'd0);
        send_command(trp_pkg::OP_TURN_LEFT, 8'd0);     // facing up
        send_command(trp_pkg::OP_MOVE, 8'd20);
        send_command(trp_pkg::OP_PRINT, 8'hff);        // step field ignored by print
        wait_drain();
    endtask

    // Undefined opcodes must leave the state alone
    task automatic test_undefined_opcodes();
        for (int i = 0; i < 9; i++)
            send_command(undefined_ops[i], 8'($urandom));
        send_command(trp_pkg::OP_PRINT, 8'd0);
        wait_drain();
    endtask

    // Mostly well-formed drawing with random content, some noise
    task automatic test_random_commands(input int n, input int idle_pct, input int stall_pct);
        logic [trp_pkg::OPCODE_W-1:0] op;
        logic [trp_pkg::STEP_W-1:0]   steps;
        int                           pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 12)      op = trp_pkg::OP_PEN_UP;
            else if (pick < 24) op = trp_pkg::OP_PEN_DOWN;
            else if (pick < 36) op = trp_pkg::OP_TURN_RIGHT;
            else if (pick < 48) op = trp_pkg::OP_TURN_LEFT;
            else if (pick < 83) op = trp_pkg::OP_MOVE;
            else if (pick < 90) op = trp_pkg::OP_PRINT;
            else                op = undefined_ops[$urandom_range(8)];
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: steps = trp_pkg::STEP_W'($urandom_range(16));
                6, 7:             steps = trp_pkg::STEP_W'($urandom_range(70));
                8:                steps = trp_pkg::STEP_W'($urandom);
                default:          steps = $urandom_range(1) ? 8'hff : 8'h00;
            endcase
            send_command(op, steps);
        end
        wait_drain();
    endtask

    // End halts the block: later commands, print included, give nothing
    task automatic test_end_halts();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_command(trp_pkg::OP_END, 8'd0);
        send_command(trp_pkg::OP_PRINT, 8'd0);
        send_command(trp_pkg::OP_PEN_DOWN, 8'd0);
        send_command(trp_pkg::OP_MOVE, 8'd30);
        send_command(trp_pkg::OP_PRINT, 8'd0);
        wait_drain();
    endtask

    initial
    begin
        reset_turtle();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_plot();
        test_undefined_opcodes();
        test_random_commands(88, 0, 0);
        test_random_commands(88, 46, 0);
        test_random_commands(88, 0, 46);
        test_random_commands(88, 32, 32);
        test_end_halts();

        $display("Ran %0d commands including %0d prints; %0d rows compared in %0d cycles.",
                 commands_sent, prints_sent, rows_checked, cycle_count);
        $display("Covered edges, saturated moves, undefined opcodes, halt and four gap mixes.");
        if (error_count == 0)
            $display("turtle_raster_plotter verification clean");
        else
            $display("turtle_raster_plotter verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/trp_pkg.sv
hw/rtl/trp_step_unit.sv
hw/rtl/trp_bitmap.sv
hw/rtl/turtle_raster_plotter.sv
hw/rtl/trp_checker.sv
verif/tb_turtle_raster_plotter.sv
